[hdl/dpu_pkg.sv]
// dpu_pkg: shared types and constants of the dib pixel unpacker
// transaction payloads, configuration register indexes and item kinds
// no dependencies
package dpu_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_PIXEL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_FROM_DATA = 3'd6;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_ROW     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  palette_index;
    logic [23:0] palette_bgr;
    logic [7:0]  row_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_argb;
    logic        row_end;
    logic        last_of_input;
  } out_item_t;

endpackage

[hdl/dpu_if.sv]
// dpu_if: valid/ready stream interfaces for row bytes in and pixels out
// depends on dpu_pkg for the payload types
interface dpu_in_if;
  import dpu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpu_out_if;
  import dpu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/dib_pixel_unpacker_core.sv]
// dib_pixel_unpacker_core: dib row bytes and palette writes in, argb8888 pixels out
// depends on dpu_pkg and the stream interfaces in dpu_if
// holds the palette memory, the byte unpacker and a two-entry output buffer

// Takes one transaction per cycle while nothing downstream stalls: a palette
// write, or one byte of a DIB row (padding included). A byte at 8, 16, 24 or 32
// bpp gives at most one pixel; at 4 bpp a byte gives up to two and at 1 bpp up to
// eight, read out one after another, because every palette pixel is one read of
// the single-port palette memory. A pixel passes through the unpack stage, the
// palette read stage and the output buffer. The user must write configuration
// through the plain write port only while no transaction is in flight; the block
// itself does not enforce it. The first byte may follow the last write in the
// next cycle. Palette entries that were never written read as undefined.
module dib_pixel_unpacker_core #(
  parameter int MAX_WIDTH     = 8192,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  dpu_in_if.sink                             bytes,
  dpu_out_if.source                          pixels,
  input  logic                               cfg_write_en,
  input  logic [dpu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dpu_pkg::*;

  localparam int COL_W    = $clog2(MAX_WIDTH + 1);
  localparam int BITS_W   = COL_W + 5;
  localparam int STRIDE_W = $clog2(MAX_WIDTH * 4 + 1);
  localparam int AW       = $clog2(PALETTE_DEPTH);

  typedef enum logic [2:0] {BPP_1, BPP_4, BPP_8, BPP_16, BPP_24, BPP_32} bpp_t;

  typedef struct packed {
    logic [15:0] run;
    logic [4:0]  shamt;
    logic        narrow;
    logic [2:0]  nbits;
  } chan_cfg_t;

  function automatic chan_cfg_t chan_prep(input logic [31:0] mask);
    logic [31:0] low;
    logic [31:0] run;
    logic [5:0]  nb;
    logic [5:0]  sh;
    chan_cfg_t   c;
    low = mask & (~mask + 32'd1);
    run = mask & ~(mask + low);
    nb  = 6'($countones(run));
    sh  = '0;
    for (int i = 0; i < 32; i++) begin
      if (low[i]) sh = sh | 6'(i);
    end
    c.run    = run[15:0];
    c.narrow = (nb < 6'd8);
    c.nbits  = nb[2:0];
    c.shamt  = c.narrow ? sh[4:0] : 5'(sh + nb - 6'd8);
    return c;
  endfunction

  function automatic logic [7:0] chan_extract(input logic [15:0] word, input chan_cfg_t c);
    logic [15:0] cw;
    logic [7:0]  x;
    logic [7:0]  r;
    cw = (word & c.run) >> c.shamt;
    x  = cw[7:0];
    r  = x;
    if (c.narrow) begin
      case (c.nbits)
        3'd1:    r = {8{x[0]}};
        3'd2:    r = {4{x[1:0]}};
        3'd3:    r = {x[2:0], x[2:0], x[2:1]};
        3'd4:    r = {2{x[3:0]}};
        3'd5:    r = {x[4:0], x[4:2]};
        3'd6:    r = {x[5:0], x[5:4]};
        3'd7:    r = {x[6:0], x[6]};
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // configuration registers
  logic [5:0]  bpp_reg;
  logic [13:0] width_reg;
  logic [8:0]  pcount_reg;
  logic [31:0] red_mask, green_mask, blue_mask;
  logic        alpha_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_reg    <= 6'd8;
      width_reg  <= 14'd1;
      pcount_reg <= 9'd256;
      red_mask   <= 32'h0000_7C00;
      green_mask <= 32'h0000_03E0;
      blue_mask  <= 32'h0000_001F;
      alpha_reg  <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_BITS_PER_PIXEL:  bpp_reg    <= cfg_data[5:0];
        REG_ROW_WIDTH:       width_reg  <= cfg_data[13:0];
        REG_PALETTE_COUNT:   pcount_reg <= cfg_data[8:0];
        REG_RED_MASK:        red_mask   <= cfg_data;
        REG_GREEN_MASK:      green_mask <= cfg_data;
        REG_BLUE_MASK:       blue_mask  <= cfg_data;
        REG_ALPHA_FROM_DATA: alpha_reg  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived configuration, registered
  bpp_t                bpp_c, bpp_code;
  logic [COL_W-1:0]    w_c, w_eff;
  logic [BITS_W-1:0]   bits_c;
  logic [BITS_W:0]     bits_sum;
  logic [STRIDE_W-1:0] stride_c, stride;
  chan_cfg_t           chan_r, chan_g, chan_b;

  always_comb begin
    unique case (bpp_reg)
      6'd1:    bpp_c = BPP_1;
      6'd4:    bpp_c = BPP_4;
      6'd8:    bpp_c = BPP_8;
      6'd16:   bpp_c = BPP_16;
      6'd24:   bpp_c = BPP_24;
      default: bpp_c = BPP_32;
    endcase
    if (width_reg == 14'd0) begin
      w_c = COL_W'(1);
    end else if (width_reg > 14'(MAX_WIDTH)) begin
      w_c = COL_W'(MAX_WIDTH);
    end else begin
      w_c = COL_W'(width_reg);
    end
    unique case (bpp_c)
      BPP_1:   bits_c = BITS_W'(w_c);
      BPP_4:   bits_c = BITS_W'(w_c) << 2;
      BPP_8:   bits_c = BITS_W'(w_c) << 3;
      BPP_16:  bits_c = BITS_W'(w_c) << 4;
      BPP_24:  bits_c = (BITS_W'(w_c) << 4) + (BITS_W'(w_c) << 3);
      default: bits_c = BITS_W'(w_c) << 5;
    endcase
    bits_sum = {1'b0, bits_c} + (BITS_W + 1)'(31);
    stride_c = STRIDE_W'({bits_sum[BITS_W:5], 2'b00});
  end

  always_ff @(posedge clk) begin
    bpp_code <= bpp_c;
    w_eff    <= w_c;
    stride   <= stride_c;
    chan_r   <= chan_prep(red_mask);
    chan_g   <= chan_prep(green_mask);
    chan_b   <= chan_prep(blue_mask);
  end

  // stream state
  logic [COL_W-1:0]    column;
  logic [STRIDE_W-1:0] row_byte_count;
  logic [1:0]          byte_phase;
  logic [23:0]         pending_bytes;

  // unpack stage
  logic        s1_valid;
  logic        s1_kind;
  logic [7:0]  s1_index;
  logic [23:0] s1_bgr;
  logic [7:0]  s1_byte;
  logic [2:0]  s1_sub;

  // palette read stage
  logic        s2_valid;
  logic        s2_pal;
  logic [31:0] s2_direct;
  logic        s2_row_end;
  logic        s2_last;
  logic [23:0] mem_q;

  // output buffer
  out_item_t obuf [2];
  logic      obuf_wptr, obuf_rptr;
  logic [1:0] obuf_cnt;
  logic      obuf_space;

  logic        small_bpp, col_open, col_last, per_last, full_px;
  logic        emit, final_px, fire, acc, s1_done, row_step, rbc_wrap;
  logic        rd_en, wr_en, s2_ready, s2_move, push, pop;
  logic [7:0]  pix_idx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [STRIDE_W-1:0] rbc_inc;
  logic [15:0] word16;
  logic [31:0] direct_pix;

  assign obuf_space = (obuf_cnt != 2'd2);
  assign s2_move    = s2_valid && obuf_space;
  assign s2_ready   = !s2_valid || obuf_space;

  always_comb begin
    small_bpp = (bpp_code inside {BPP_1, BPP_4, BPP_8});
    col_open  = (column < w_eff);
    col_last  = ((column + COL_W'(1)) == w_eff);
    unique case (bpp_code)
      BPP_1:   per_last = (s1_sub == 3'd7);
      BPP_4:   per_last = (s1_sub == 3'd1);
      default: per_last = 1'b1;
    endcase
    unique case (bpp_code)
      BPP_16:  full_px = (byte_phase >= 2'd1);
      BPP_24:  full_px = (byte_phase >= 2'd2);
      default: full_px = (byte_phase >= 2'd3);
    endcase
    unique case (bpp_code)
      BPP_1:   pix_idx = {7'd0, s1_byte[7]};
      BPP_4:   pix_idx = {4'd0, s1_byte[7:4]};
      default: pix_idx = s1_byte;
    endcase

    emit     = 1'b0;
    final_px = 1'b1;
    acc      = 1'b0;
    wr_en    = 1'b0;
    if (s1_valid) begin
      if (s1_kind == KIND_PALETTE) begin
        wr_en = ({1'b0, s1_index} < 9'(PALETTE_DEPTH));
      end else if (col_open) begin
        if (small_bpp) begin
          emit     = 1'b1;
          final_px = per_last || col_last;
        end else if (full_px) begin
          emit = 1'b1;
        end else begin
          acc = 1'b1;
        end
      end
    end
    fire     = emit && s2_ready;
    rd_en    = fire && small_bpp;
    s1_done  = s1_valid && (!emit || (fire && final_px));
    row_step = s1_done && (s1_kind == KIND_ROW);
    rbc_inc  = row_byte_count + STRIDE_W'(1);
    rbc_wrap = (rbc_inc >= stride);

    if (({1'b0, pix_idx} < pcount_reg) && ({1'b0, pix_idx} < 9'(PALETTE_DEPTH))) begin
      rd_addr = AW'(pix_idx);
    end else begin
      rd_addr = '0;
    end
    wr_addr = AW'(s1_index);

    word16 = {s1_byte, pending_bytes[7:0]};
    unique case (bpp_code)
      BPP_16:  direct_pix = {8'hFF, chan_extract(word16, chan_r),
                             chan_extract(word16, chan_g), chan_extract(word16, chan_b)};
      BPP_24:  direct_pix = {8'hFF, s1_byte, pending_bytes[15:0]};
      default: direct_pix = {alpha_reg ? s1_byte : 8'hFF, pending_bytes};
    endcase
  end

  assign bytes.ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
    if (bytes.valid && bytes.ready) begin
      s1_kind  <= bytes.data.kind;
      s1_index <= bytes.data.palette_index;
      s1_bgr   <= bytes.data.palette_bgr;
      s1_byte  <= bytes.data.row_byte;
      s1_sub   <= 3'd0;
    end else if (fire && !final_px) begin
      s1_sub  <= s1_sub + 3'd1;
      s1_byte <= (bpp_code == BPP_1) ? {s1_byte[6:0], 1'b0} : {s1_byte[3:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      row_byte_count <= '0;
      byte_phase     <= 2'd0;
      pending_bytes  <= 24'd0;
    end else begin
      if (row_step && rbc_wrap) begin
        column <= '0;
      end else if (fire) begin
        column <= column + COL_W'(1);
      end
      if (row_step) begin
        row_byte_count <= rbc_wrap ? '0 : rbc_inc;
      end
      if ((row_step && rbc_wrap) || (fire && !small_bpp)) begin
        byte_phase    <= 2'd0;
        pending_bytes <= 24'd0;
      end else if (acc) begin
        byte_phase <= byte_phase + 2'd1;
        case (byte_phase)
          2'd0:    pending_bytes[7:0]   <= s1_byte;
          2'd1:    pending_bytes[15:8]  <= s1_byte;
          default: pending_bytes[23:16] <= s1_byte;
        endcase
      end
    end
  end

  // palette memory, read-first
  logic [23:0] palette_mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[wr_addr] <= s1_bgr;
    end
    if (rd_en) begin
      mem_q <= palette_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (fire) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
    if (fire) begin
      s2_pal     <= small_bpp;
      s2_direct  <= direct_pix;
      s2_row_end <= col_last;
      s2_last    <= final_px;
    end
  end

  assign push = s2_move;
  assign pop  = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_wptr <= 1'b0;
      obuf_rptr <= 1'b0;
      obuf_cnt  <= 2'd0;
    end else begin
      if (push) obuf_wptr <= !obuf_wptr;
      if (pop) obuf_rptr <= !obuf_rptr;
      obuf_cnt <= obuf_cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      obuf[obuf_wptr].pixel_argb    <= s2_pal ? {8'hFF, mem_q} : s2_direct;
      obuf[obuf_wptr].row_end       <= s2_row_end;
      obuf[obuf_wptr].last_of_input <= s2_last;
    end
  end

  assign pixels.valid = (obuf_cnt != 2'd0);
  assign pixels.data  = obuf[obuf_rptr];

`ifndef ASSERT_OFF
  a_obuf_bound: assert property (@(posedge clk) disable iff (rst)
    obuf_cnt != 2'd3)
    else $error("output buffer count out of range");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> s2_valid && s2_pal)
    else $error("palette read without a pixel in the read stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_done |=> s1_valid && $stable(s1_kind) && $stable(s1_index))
    else $error("unpack stage lost its transaction");

  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.data.row_end |-> pixels.data.last_of_input)
    else $error("row end pixel not last of its byte");

  a_phase_bytes: assert property (@(posedge clk) disable iff (rst)
    byte_phase != 2'd3 |-> pending_bytes[23:16] == 8'd0)
    else $error("held byte beyond the byte phase");
`endif

endmodule

[tb/dpu_pixel_checker.sv]
`timescale 1ns / 1ps
// dpu_pixel_checker: watches the byte, pixel and register ports of the dib pixel unpacker
// predicts the argb8888 pixels of every accepted row byte and compares them in order
// depends on dpu_pkg and the stream interfaces in dpu_if
module dpu_pixel_checker (
  input  logic                            clk,
  input  logic                            rst,
  dpu_in_if                               byte_mon,
  dpu_out_if                              pixel_mon,
  input  logic                            cfg_write_en,
  input  logic [dpu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              outstanding
);
  import dpu_pkg::*;

  localparam int MAX_ROW_PIXELS = 8192;

  logic [5:0]  bpp_reg;
  logic [13:0] width_reg;
  logic [8:0]  pcount_reg;
  logic [31:0] red_m;
  logic [31:0] green_m;
  logic [31:0] blue_m;
  logic        alpha_reg;

  logic [23:0] palette_copy [256];
  logic [23:0] held_bytes;
  int          held_count;
  int          column;
  int          row_bytes;

  out_item_t   expected_pixels [$];
  out_item_t   want;
  out_item_t   got;

  function automatic logic [7:0] widen_channel(input logic [15:0] word, input logic [31:0] mask);
    int          lsb;
    int          run;
    int          pos;
    logic [31:0] field;
    logic [7:0]  acc;
    if (mask == '0) return 8'h00;
    lsb = 0;
    while (!mask[lsb]) lsb++;
    run = 0;
    while (lsb + run < 32 && mask[lsb + run]) run++;
    field = ({16'h0000, word} & mask) >> lsb;
    if (run >= 8) return 8'(field >> (run - 8));
    field = field & ((32'd1 << run) - 1);
    // repeat the short channel until all 8 bits are filled
    acc = '0;
    pos = 8;
    while (pos > 0) begin
      pos = pos - run;
      if (pos >= 0) acc = acc | 8'(field << pos);
      else acc = acc | 8'(field >> -pos);
    end
    return acc;
  endfunction

  task automatic decode_byte(input in_item_t it);
    int          depth;
    int          width;
    int          stride;
    int          need;
    int          per;
    logic [7:0]  b;
    logic [7:0]  idx;
    logic [15:0] word;
    logic [31:0] argb;
    out_item_t   px;
    out_item_t   batch [$];
    if (it.kind == KIND_PALETTE) begin
      palette_copy[it.palette_index] = it.palette_bgr;
      return;
    end
    case (bpp_reg)
      6'd1, 6'd4, 6'd8, 6'd16, 6'd24: depth = bpp_reg;
      default: depth = 32;
    endcase
    if (width_reg == 0) width = 1;
    else if (width_reg > MAX_ROW_PIXELS) width = MAX_ROW_PIXELS;
    else width = width_reg;
    stride = ((width * depth + 31) / 32) * 4;
    b = it.row_byte;
    if (column < width) begin
      if (depth <= 8) begin
        per = 8 / depth;
        for (int i = 0; i < per && column < width; i++) begin
          idx = (b >> (8 - depth * (i + 1))) & ((1 << depth) - 1);
          if (idx >= pcount_reg) idx = 8'd0;
          px.pixel_argb = {8'hFF, palette_copy[idx]};
          px.row_end = (column + 1 == width);
          px.last_of_input = 1'b0;
          batch.push_back(px);
          column++;
        end
      end else begin
        need = depth / 8;
        if (held_count + 1 >= need) begin
          case (depth)
            16: begin
              word = {b, held_bytes[7:0]};
              argb = {8'hFF, widen_channel(word, red_m), widen_channel(word, green_m),
                      widen_channel(word, blue_m)};
            end
            24: argb = {8'hFF, b, held_bytes[15:0]};
            default: argb = {(alpha_reg ? b : 8'hFF), held_bytes};
          endcase
          px.pixel_argb = argb;
          px.row_end = (column + 1 == width);
          px.last_of_input = 1'b0;
          batch.push_back(px);
          column++;
          held_bytes = '0;
          held_count = 0;
        end else begin
          held_bytes = held_bytes | ({16'h0000, b} << (8 * held_count));
          held_count = (held_count + 1) % 4;
        end
      end
    end
    row_bytes++;
    if (row_bytes >= stride) begin
      row_bytes = 0;
      column = 0;
      held_bytes = '0;
      held_count = 0;
    end
    foreach (batch[i]) begin
      px = batch[i];
      px.last_of_input = (i == batch.size() - 1);
      expected_pixels.push_back(px);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      bpp_reg = 6'd8;
      width_reg = 14'd1;
      pcount_reg = 9'd256;
      red_m = 32'h0000_7C00;
      green_m = 32'h0000_03E0;
      blue_m = 32'h0000_001F;
      alpha_reg = 1'b0;
      held_bytes = '0;
      held_count = 0;
      column = 0;
      row_bytes = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_BITS_PER_PIXEL:  bpp_reg = cfg_data[5:0];
          REG_ROW_WIDTH:       width_reg = cfg_data[13:0];
          REG_PALETTE_COUNT:   pcount_reg = cfg_data[8:0];
          REG_RED_MASK:        red_m = cfg_data;
          REG_GREEN_MASK:      green_m = cfg_data;
          REG_BLUE_MASK:       blue_m = cfg_data;
          REG_ALPHA_FROM_DATA: alpha_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (byte_mon.valid && byte_mon.ready) decode_byte(byte_mon.data);
      if (pixel_mon.valid && pixel_mon.ready) begin
        got = pixel_mon.data;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: pixel with none expected, expected none actual %h", $time, got);
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel_argb !== want.pixel_argb) begin
            errors++;
            $display("%0t: pixel_argb expected %h actual %h", $time, want.pixel_argb,
                     got.pixel_argb);
          end
          if (got.row_end !== want.row_end) begin
            errors++;
            $display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
          end
          if (got.last_of_input !== want.last_of_input) begin
            errors++;
            $display("%0t: last_of_input expected %b actual %b", $time, want.last_of_input,
                     got.last_of_input);
          end
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench: drives palette writes, row bytes and register writes into dib_pixel_unpacker_core
// depends on dpu_pkg, dpu_if, the core and dpu_pixel_checker, which does all the checking
module testbench;
  import dpu_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_BUDGET   = 420;
  localparam int PALETTE_FILL  = 128;
  localparam int SETTLE_CYCLES = 32;

  typedef struct {
    logic [5:0]  bpp;
    logic [13:0] width;
    logic [8:0]  pcount;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        alpha;
  } dib_regs_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   errors;
  int   outstanding;
  int   cycles = 0;
  int   stall_left = 0;
  int   filled = 0;
  int   items_sent = 0;
  logic in_gaps = 1'b0;
  logic out_stalls = 1'b0;
  bit   written [256];

  dpu_in_if  byte_ch ();
  dpu_out_if pix_ch ();

  dib_pixel_unpacker_core dut (
    .clk          (clk),
    .rst          (rst),
    .bytes        (byte_ch),
    .pixels       (pix_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dpu_pixel_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .byte_mon     (byte_ch),
    .pixel_mon    (pix_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[dib_pixel_unpacker_core] ERROR");
      $finish;
    end
  end

  // pixel sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      pix_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_ch.ready <= 1'b0;
    end else if (out_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= 1'b1;
    end
  end

  function automatic int eff_depth(input logic [5:0] bpp);
    case (bpp)
      6'd1, 6'd4, 6'd8, 6'd16, 6'd24: return bpp;
      default: return 32;
    endcase
  endfunction

  function automatic logic [31:0] random_run();
    int lsb;
    int len;
    lsb = $urandom_range(0, 15);
    len = $urandom_range(1, 16);
    return ((32'd1 << len) - 1) << lsb;
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data <= it;
    do @(posedge clk); while (!byte_ch.ready);
    items_sent++;
  endtask

  task automatic send_row_byte(input logic [7:0] v);
    in_item_t it;
    it.kind = KIND_ROW;
    it.palette_index = 8'($urandom);
    it.palette_bgr = 24'($urandom);
    it.row_byte = v;
    send_item(it);
  endtask

  task automatic send_four(input logic [31:0] v);
    send_row_byte(v[31:24]);
    send_row_byte(v[23:16]);
    send_row_byte(v[15:8]);
    send_row_byte(v[7:0]);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [23:0] bgr);
    in_item_t it;
    it.kind = KIND_PALETTE;
    it.palette_index = idx;
    it.palette_bgr = bgr;
    it.row_byte = 8'($urandom);
    send_item(it);
    written[idx] = 1'b1;
    while (filled < 256 && written[filled]) filled++;
  endtask

  // stop sending, let every expected pixel arrive and the pipeline settle
  task automatic drain();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_regs(input dib_regs_t r);
    write_reg(REG_BITS_PER_PIXEL, 32'(r.bpp));
    write_reg(REG_ROW_WIDTH, 32'(r.width));
    write_reg(REG_PALETTE_COUNT, 32'(r.pcount));
    write_reg(REG_RED_MASK, r.red);
    write_reg(REG_GREEN_MASK, r.green);
    write_reg(REG_BLUE_MASK, r.blue);
    write_reg(REG_ALPHA_FROM_DATA, 32'(r.alpha));
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    dib_regs_t r;
    int        phase;
    int        depth;
    int        w;
    int        stride;
    int        n;
    int        pc;
    logic      quiet;

    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    in_gaps = 1'b1;
    out_stalls = 1'b1;
    r = '{bpp: 6'd8, width: 14'd1, pcount: 9'd256, red: 32'h7C00, green: 32'h03E0,
          blue: 32'h001F, alpha: 1'b0};

    // directed: palette base, then each depth with its corner cases
    send_palette(8'd0, 24'hFFFFFF);
    send_palette(8'd1, 24'h000000);
    send_palette(8'd2, 24'hA5C3E1);
    send_palette(8'd3, 24'h5A3C1E);
    send_four(32'h03FF_0080);
    drain();
    r.bpp = 6'd1; r.width = 14'd10; r.pcount = 9'd2;
    apply_regs(r);
    send_four(32'hA5C0_3C00);
    drain();
    r.bpp = 6'd4; r.width = 14'd3; r.pcount = 9'd3;
    apply_regs(r);
    send_four(32'h3F21_FF00);
    drain();
    r.bpp = 6'd16; r.width = 14'd1; r.red = 32'h0; r.green = 32'h0A50; r.blue = 32'hFFFF;
    apply_regs(r);
    send_four(32'h3412_AA55);
    drain();
    r.bpp = 6'd24;
    apply_regs(r);
    send_four(32'h1122_3344);
    drain();
    r.bpp = 6'd2; r.width = 14'd0; r.alpha = 1'b1;
    apply_regs(r);
    send_four(32'h0102_0380);

    phase = 0;
    while (items_sent < ITEM_BUDGET) begin
      for (int i = 0; i < 32 && filled < PALETTE_FILL; i++) begin
        send_palette(8'(filled), 24'($urandom));
      end
      quiet = (items_sent >= ITEM_BUDGET - 80);
      in_gaps = !quiet && $urandom_range(0, 3) != 0;
      out_stalls = !quiet && $urandom_range(0, 3) != 0;

      case ($urandom_range(0, 13))
        0, 1:   r.bpp = 6'd1;
        2, 3:   r.bpp = 6'd4;
        4, 5:   r.bpp = 6'd8;
        6, 7:   r.bpp = 6'd16;
        8, 9:   r.bpp = 6'd24;
        10, 11: r.bpp = 6'd32;
        default: r.bpp = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 9))
        0: r.width = 14'd0;
        1: r.width = 14'd8192;
        2: r.width = 14'($urandom_range(8193, 16383));
        3: r.width = 14'($urandom_range(21, 300));
        default: r.width = 14'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 5))
        0: begin r.red = 32'h7C00; r.green = 32'h03E0; r.blue = 32'h001F; end
        1: begin r.red = 32'hF800; r.green = 32'h07E0; r.blue = 32'h001F; end
        2: begin r.red = 32'h0F00; r.green = 32'h00F0; r.blue = 32'h000F; end
        3: begin r.red = $urandom; r.green = $urandom; r.blue = $urandom; end
        4: begin r.red = random_run(); r.green = random_run(); r.blue = random_run(); end
        default: begin r.red = 32'h0; r.green = $urandom & 32'hFFFF; r.blue = 32'hFFFF_FFFF; end
      endcase
      r.alpha = 1'($urandom);
      if (phase == 1) begin
        r.bpp = 6'd1; r.width = 14'd8192;
      end else if (phase == 2) begin
        r.width = 14'd16383;
      end

      // indices that can reach the palette must hit written entries
      depth = eff_depth(r.bpp);
      do begin
        case ($urandom_range(0, 5))
          0: pc = 1;
          1: pc = 256;
          2: pc = $urandom_range(257, 511);
          default: pc = $urandom_range(1, filled);
        endcase
      end while (depth <= 8 && ((pc < (1 << depth)) ? pc : (1 << depth)) > filled);
      r.pcount = 9'(pc);
      if (phase == 1) r.pcount = 9'd256;
      else if (phase == 2) r.pcount = 9'd1;

      drain();
      apply_regs(r);

      w = (r.width == 0) ? 1 : ((r.width > 8192) ? 8192 : r.width);
      stride = ((w * depth + 31) / 32) * 4;
      if (stride > 64) begin
        n = $urandom_range(3, 24);
      end else begin
        n = stride * $urandom_range(1, 64 / stride);
        if ($urandom_range(0, 5) == 0) n += $urandom_range(1, stride);
      end
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 11) == 0) send_palette(8'($urandom), 24'($urandom));
        send_row_byte(8'($urandom));
      end
      phase++;
    end

    in_gaps = 1'b0;
    out_stalls = 1'b0;
    drain();
    if (errors == 0) $display("[dib_pixel_unpacker_core] OK");
    else $display("[dib_pixel_unpacker_core] ERROR");
    $finish;
  end

endmodule
